>>> rtl/core/irpd_pkg.sv
`default_nettype none

package irpd_pkg;

	localparam int FRAME_BITS_DEF = 32;
	localparam int CNT_W          = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 8;

	localparam logic [1:0] MODE_EDGE = 2'd0;
	localparam logic [1:0] MODE_OVF  = 2'd1;
	localparam logic [1:0] MODE_CLR  = 2'd2;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_LEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 3'd5;

	localparam logic [7:0] LEAD_MIN_RST = 8'd175;
	localparam logic [7:0] LEAD_MAX_RST = 8'd216;
	localparam logic [7:0] ZERO_MIN_RST = 8'd13;
	localparam logic [7:0] ZERO_MAX_RST = 8'd19;
	localparam logic [7:0] ONE_MIN_RST  = 8'd28;
	localparam logic [7:0] ONE_MAX_RST  = 8'd37;

	typedef struct packed {
		logic [7:0] lead_min;
		logic [7:0] lead_max;
		logic [7:0] zero_min;
		logic [7:0] zero_max;
		logic [7:0] one_min;
		logic [7:0] one_max;
	} cfg_t;

	function automatic logic in_window(input logic [7:0] v, input logic [7:0] lo,
		input logic [7:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/irpd_cfg.sv
`default_nettype none

module irpd_cfg import irpd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_min <= LEAD_MIN_RST;
			cfg_q.lead_max <= LEAD_MAX_RST;
			cfg_q.zero_min <= ZERO_MIN_RST;
			cfg_q.zero_max <= ZERO_MAX_RST;
			cfg_q.one_min  <= ONE_MIN_RST;
			cfg_q.one_max  <= ONE_MAX_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LEAD_MIN: cfg_q.lead_min <= cfg_data;
				CFG_LEAD_MAX: cfg_q.lead_max <= cfg_data;
				CFG_ZERO_MIN: cfg_q.zero_min <= cfg_data;
				CFG_ZERO_MAX: cfg_q.zero_max <= cfg_data;
				CFG_ONE_MIN:  cfg_q.one_min  <= cfg_data;
				CFG_ONE_MAX:  cfg_q.one_max  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/ir_pulse_distance_decoder.sv
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_ready    mode, interval
// out       out_valid / out_ready  phase, frame_done, check_ok, four frame bytes
// cfg       cfg_wr_en              cfg_index, cfg_data
//
// Each event is registered, decoded from the input register and its result registered in the
// result register, from which it is offered. One event per cycle is sustained while the
// output is not stalled; the decode step between the input register and the result
// register sets that figure.
// Reset loads the default windows and clears the phase, bit count and stored bytes.
// A stalled output holds its result and stops a full input register from advancing.

module ir_pulse_distance_decoder import irpd_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            mode,
	input  wire logic [7:0]            interval,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 phase,
	output logic                       frame_done,
	output logic                       check_ok,
	output logic [7:0]                 address_low,
	output logic [7:0]                 address_high,
	output logic [7:0]                 command,
	output logic [7:0]                 command_inverse
);

	localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

	cfg_t cfg;

	logic             valid_s1;
	logic [1:0]       mode_s1;
	logic [7:0]       interval_s1;
	logic             advance;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       shift_q;
	logic [7:0]       bytes_q [4];

	logic [1:0]       phase_d;
	logic [CNT_W-1:0] cnt_d;
	logic [7:0]       shift_d;
	logic [7:0]       bytes_d [4];
	logic [1:0]       byte_idx;
	logic             done_d;
	logic             ok_d;
	logic             zero_hit;
	logic             one_hit;
	logic             leader_hit;

	logic             valid_s2;
	logic [1:0]       phase_s2;
	logic             done_s2;
	logic             ok_s2;
	logic [7:0]       bytes_s2 [4];

	irpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1     <= mode;
			interval_s1 <= interval;
		end
	end

	assign leader_hit = in_window(interval_s1, cfg.lead_min, cfg.lead_max);
	assign zero_hit   = in_window(interval_s1, cfg.zero_min, cfg.zero_max);
	assign one_hit    = in_window(interval_s1, cfg.one_min, cfg.one_max);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		bytes_d  = bytes_q;
		done_d   = 1'b0;
		byte_idx = 2'd0;
		unique case (mode_s1)
			MODE_OVF: phase_d = PH_IDLE;
			MODE_CLR: bytes_d[2] = 8'd0;
			MODE_EDGE: begin
				unique case (phase_q)
					PH_IDLE: phase_d = PH_LEADER;
					PH_LEADER: begin
						if (leader_hit) begin
							phase_d = PH_DATA;
							cnt_d   = '0;
							shift_d = 8'd0;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_DATA: begin
						shift_d = {1'b0, shift_q[7:1]};
						priority if (zero_hit) begin
							shift_d[7] = 1'b0;
						end else if (one_hit) begin
							shift_d[7] = 1'b1;
						end else begin
							phase_d = PH_IDLE;
						end
						cnt_d    = cnt_q + CNT_W'(1);
						byte_idx = cnt_d[4:3] - 2'd1;
						if (cnt_d[2:0] == 3'd0 && cnt_d != '0) begin
							bytes_d[byte_idx] = shift_d;
							shift_d           = 8'd0;
						end
						if (cnt_d == FRAME_CNT) begin
							done_d  = 1'b1;
							phase_d = PH_IDLE;
							cnt_d   = '0;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		ok_d = done_d && (bytes_d[3] == ~bytes_d[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			shift_q  <= 8'd0;
			bytes_q  <= '{default: 8'd0};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				shift_q <= shift_d;
				bytes_q <= bytes_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			phase_s2 <= phase_d;
			done_s2  <= done_d;
			ok_s2    <= ok_d;
			bytes_s2 <= bytes_d;
		end
	end

	assign out_valid       = valid_s2;
	assign phase           = phase_s2;
	assign frame_done      = done_s2;
	assign check_ok        = ok_s2;
	assign address_low     = bytes_s2[0];
	assign address_high    = bytes_s2[1];
	assign command         = bytes_s2[2];
	assign command_inverse = bytes_s2[3];

endmodule

`default_nettype wire

>>> dv/irpd_tb_pkg.sv
package irpd_tb_pkg;
	import irpd_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] phase;
		logic       frame_done;
		logic       check_ok;
		logic [7:0] address_low;
		logic [7:0] address_high;
		logic [7:0] command;
		logic [7:0] command_inverse;
	} ir_result_t;

	class ir_frame_scoreboard;
		cfg_t       win;
		logic [1:0] rx_phase;
		logic [5:0] bit_cnt;
		logic [7:0] shift_reg;
		logic [7:0] frame_bytes [4];
		ir_result_t pending_results [$];
		int         errors;
		int         frames_seen;
		int         checks_seen;
		int         bad_intervals;

		function new();
			win = '{LEAD_MIN_RST, LEAD_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
				ONE_MIN_RST, ONE_MAX_RST};
			rx_phase = PH_IDLE;
			bit_cnt = '0;
			shift_reg = '0;
			foreach (frame_bytes[i]) frame_bytes[i] = '0;
			errors = 0;
			frames_seen = 0;
			checks_seen = 0;
			bad_intervals = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void set_window(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
			case (idx)
				CFG_LEAD_MIN: win.lead_min = val;
				CFG_LEAD_MAX: win.lead_max = val;
				CFG_ZERO_MIN: win.zero_min = val;
				CFG_ZERO_MAX: win.zero_max = val;
				CFG_ONE_MIN:  win.one_min = val;
				CFG_ONE_MAX:  win.one_max = val;
				default: ;
			endcase
		endfunction

		function bit fits(input logic [7:0] v, input logic [7:0] lo, input logic [7:0] hi);
			return (v >= lo) && (v <= hi);
		endfunction

		function void take_event(input logic [1:0] ev, input logic [7:0] ticks);
			ir_result_t r;
			logic [2:0] slot;
			r = '0;
			case (ev)
				MODE_OVF: rx_phase = PH_IDLE;
				MODE_CLR: frame_bytes[2] = 8'h00;
				MODE_EDGE: begin
					case (rx_phase)
						PH_IDLE: rx_phase = PH_LEADER;
						PH_LEADER: begin
							if (fits(ticks, win.lead_min, win.lead_max)) begin
								rx_phase = PH_DATA;
								bit_cnt = '0;
								shift_reg = '0;
							end else begin
								rx_phase = PH_IDLE;
							end
						end
						PH_DATA: begin
							shift_reg = {1'b0, shift_reg[7:1]};
							if (!fits(ticks, win.zero_min, win.zero_max)) begin
								if (fits(ticks, win.one_min, win.one_max)) begin
									shift_reg[7] = 1'b1;
								end else begin
									rx_phase = PH_IDLE;
									bad_intervals++;
								end
							end
							bit_cnt = bit_cnt + 6'd1;
							if (bit_cnt[2:0] == 3'd0 && bit_cnt != 6'd0) begin
								slot = bit_cnt[5:3] - 3'd1;
								frame_bytes[slot[1:0]] = shift_reg;
								shift_reg = 8'h00;
							end
							if (bit_cnt == 6'(FRAME_BITS_DEF)) begin
								r.frame_done = 1'b1;
								r.check_ok = ((~frame_bytes[2]) == frame_bytes[3]);
								rx_phase = PH_IDLE;
								bit_cnt = '0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			r.phase = rx_phase;
			r.address_low = frame_bytes[0];
			r.address_high = frame_bytes[1];
			r.command = frame_bytes[2];
			r.command_inverse = frame_bytes[3];
			pending_results.push_back(r);
		endfunction

		function void match(input string name, input logic [7:0] want, input logic [7:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, actual %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void compare_result(input ir_result_t seen);
			ir_result_t want;
			if (pending_results.size() == 0) begin
				$error("Result with no event waiting: phase %0d, frame_done %0d",
					seen.phase, seen.frame_done);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (want.frame_done) frames_seen++;
			if (want.check_ok) checks_seen++;
			match("phase", 8'(want.phase), 8'(seen.phase));
			match("frame_done", 8'(want.frame_done), 8'(seen.frame_done));
			match("check_ok", 8'(want.check_ok), 8'(seen.check_ok));
			match("address_low", want.address_low, seen.address_low);
			match("address_high", want.address_high, seen.address_high);
			match("command", want.command, seen.command);
			match("command_inverse", want.command_inverse, seen.command_inverse);
		endfunction
	endclass

endpackage

>>> dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import irpd_pkg::*;
	import irpd_tb_pkg::*;

	localparam cfg_t WIN_DEFAULT = '{8'd175, 8'd216, 8'd13, 8'd19, 8'd28, 8'd37};
	localparam cfg_t WIN_WIDE    = '{8'd120, 8'd240, 8'd10, 8'd40, 8'd30, 8'd70};
	localparam cfg_t WIN_LOW     = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd1, 8'd255};
	localparam cfg_t WIN_HIGH    = '{8'd255, 8'd255, 8'd0, 8'd127, 8'd128, 8'd255};
	localparam cfg_t WIN_EMPTY   = '{8'd255, 8'd0, 8'd200, 8'd100, 8'd255, 8'd254};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	logic [7:0]            interval;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            phase;
	logic                  frame_done;
	logic                  check_ok;
	logic [7:0]            address_low;
	logic [7:0]            address_high;
	logic [7:0]            command;
	logic [7:0]            command_inverse;

	ir_frame_scoreboard sb = new();

	int items_sent   = 0;
	int frames_sent  = 0;
	int tx_idle_pct  = 21;
	int rx_idle_pct  = 84;
	bit burst        = 1'b0;
	bit hold_request = 1'b0;

	logic [9:0] opening_events [25] = '{
		{MODE_SPARE, 8'd255}, {MODE_CLR, 8'd0}, {MODE_OVF, 8'd170}, {MODE_EDGE, 8'd0},
		{MODE_EDGE, 8'd174}, {MODE_EDGE, 8'd255}, {MODE_EDGE, 8'd217}, {MODE_EDGE, 8'd0},
		{MODE_EDGE, 8'd175}, {MODE_EDGE, 8'd13}, {MODE_EDGE, 8'd19}, {MODE_EDGE, 8'd28},
		{MODE_EDGE, 8'd37}, {MODE_SPARE, 8'd85}, {MODE_CLR, 8'd255}, {MODE_EDGE, 8'd12},
		{MODE_EDGE, 8'd255}, {MODE_EDGE, 8'd216}, {MODE_EDGE, 8'd20}, {MODE_EDGE, 8'd0},
		{MODE_OVF, 8'd15}, {MODE_EDGE, 8'd1}, {MODE_EDGE, 8'd200}, {MODE_EDGE, 8'd38},
		{MODE_EDGE, 8'd27}
	};

	ir_pulse_distance_decoder u_dut (.*);

	always #5ns clk = ~clk;

	task automatic offer(input logic [1:0] ev, input logic [7:0] ticks);
		if (!burst && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= ev;
		interval <= ticks;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.take_event(ev, ticks);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_window(idx, val);
	endtask

	task automatic load_windows(input cfg_t w);
		write_reg(CFG_LEAD_MIN, w.lead_min);
		write_reg(CFG_LEAD_MAX, w.lead_max);
		write_reg(CFG_ZERO_MIN, w.zero_min);
		write_reg(CFG_ZERO_MAX, w.zero_max);
		write_reg(CFG_ONE_MIN, w.one_min);
		write_reg(CFG_ONE_MAX, w.one_max);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi);
		if (lo <= hi) return 8'($urandom_range(hi, lo));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] stray();
		logic [7:0] v;
		v = 8'($urandom);
		for (int n = 0; n < 16; n++) begin
			v = 8'($urandom);
			if (!(v >= sb.win.zero_min && v <= sb.win.zero_max) &&
				!(v >= sb.win.one_min && v <= sb.win.one_max)) return v;
		end
		return v;
	endfunction

	function automatic void set_profile();
		if (items_sent < 440) begin
			tx_idle_pct = 21;
			rx_idle_pct = 84;
		end else if (items_sent < 860) begin
			tx_idle_pct = 84;
			rx_idle_pct = 21;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endfunction

	// Bits go out LSB first: address low, address high, command, inverse.
	task automatic send_frame(input logic [31:0] word);
		int bad_at;
		int cut_at;
		int k;
		bad_at = -1;
		cut_at = -1;
		case ($urandom_range(9))
			0: bad_at = $urandom_range(31);
			1: bad_at = 8 * $urandom_range(3) + 7;
			2: if ($urandom_range(1) == 1) cut_at = $urandom_range(31);
			default: ;
		endcase
		frames_sent++;
		if (sb.rx_phase != PH_IDLE || $urandom_range(2) == 0) offer(MODE_OVF, 8'($urandom));
		offer(MODE_EDGE, 8'($urandom));
		offer(MODE_EDGE, pick(sb.win.lead_min, sb.win.lead_max));
		for (k = 0; k < 32; k++) begin
			if (k == cut_at) begin
				offer(MODE_OVF, 8'($urandom));
				return;
			end
			if ($urandom_range(39) == 0)
				offer(($urandom_range(1) == 1) ? MODE_CLR : MODE_SPARE, 8'($urandom));
			if (k == bad_at) begin
				offer(MODE_EDGE, stray());
				return;
			end
			if (word[k])
				offer(MODE_EDGE, pick(sb.win.one_min, sb.win.one_max));
			else
				offer(MODE_EDGE, pick(sb.win.zero_min, sb.win.zero_max));
		end
	endtask

	task automatic run_random(input int budget);
		int stop_at;
		logic [7:0] cmd;
		logic [31:0] word;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			set_profile();
			if ($urandom_range(99) < 70) begin
				cmd = 8'($urandom);
				word = {($urandom_range(9) < 7) ? ~cmd : 8'($urandom), cmd, 16'($urandom)};
				send_frame(word);
			end else begin
				repeat ($urandom_range(4, 1)) offer(2'($urandom), 8'($urandom));
			end
			if ($urandom_range(49) == 0) drain();
		end
	endtask

	initial begin
		ir_result_t seen;
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			// A result transaction completes on any edge where out_valid and out_ready are both high.
			if (out_valid && out_ready) begin
				seen.phase = phase;
				seen.frame_done = frame_done;
				seen.check_ok = check_ok;
				seen.address_low = address_low;
				seen.address_high = address_high;
				seen.command = command;
				seen.command_inverse = command_inverse;
				sb.compare_result(seen);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		cfg_t win_rand;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_LEAD_MIN;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_EDGE;
		interval = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_events[i]) offer(opening_events[i][9:8], opening_events[i][7:0]);
		drain();

		load_windows(WIN_DEFAULT);
		burst = 1'b1;
		hold_request = 1'b1;
		repeat (24) offer(2'($urandom), 8'($urandom));
		burst = 1'b0;
		drain();
		run_random(240);
		drain();

		load_windows(WIN_WIDE);
		run_random(240);
		drain();
		load_windows(WIN_LOW);
		run_random(240);
		drain();
		load_windows(WIN_HIGH);
		run_random(240);
		drain();
		load_windows(WIN_EMPTY);
		run_random(60);
		drain();

		win_rand.lead_min = 8'($urandom_range(150));
		win_rand.lead_max = win_rand.lead_min + 8'($urandom_range(100));
		win_rand.zero_min = 8'($urandom_range(40));
		win_rand.zero_max = win_rand.zero_min + 8'($urandom_range(15));
		win_rand.one_min = win_rand.zero_max + 8'($urandom_range(20, 1));
		win_rand.one_max = win_rand.one_min + 8'($urandom_range(30));
		load_windows(win_rand);
		run_random(190);
		drain();

		$display("Sent %0d events with %0d frame attempts over six window settings.",
			items_sent, frames_sent);
		$display("Saw %0d complete frames, %0d with a matching inverse, %0d bad data intervals.",
			sb.frames_seen, sb.checks_seen, sb.bad_intervals);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#3ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
